// ----- src/lpr_pkg.sv -----
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants of the line pixel rasterizer.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int CoordBits      = 12;
  localparam int DimBits        = 13;
  localparam int OffsetBits     = 26;
  localparam int ErrBits        = 14;
  localparam int BppBits        = 3;
  localparam int CountBits      = 3;
  localparam int FbIndexBits    = 2;
  localparam int MaxFramebuffers = 4;

  // Configuration register indexes.
  localparam logic [1:0] RegFbWidth  = 2'd0;
  localparam logic [1:0] RegFbHeight = 2'd1;
  localparam logic [1:0] RegBpp      = 2'd2;
  localparam logic [1:0] RegFbCount  = 2'd3;

  // Request kinds.
  localparam logic KindStart = 1'b0;
  localparam logic KindTick  = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic [FbIndexBits-1:0] fb_index;
    logic [CoordBits-1:0]   start_x;
    logic [CoordBits-1:0]   start_y;
    logic [CoordBits-1:0]   end_x;
    logic [CoordBits-1:0]   end_y;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
  } lpr_in_t;

  typedef struct packed {
    logic [CoordBits-1:0]  pixel_x;
    logic [CoordBits-1:0]  pixel_y;
    logic [OffsetBits-1:0] byte_offset;
    logic                  in_bounds;
    logic [7:0]            color_red;
    logic [7:0]            color_green;
    logic [7:0]            color_blue;
    logic                  last;
  } lpr_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCALE
  } lpr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // load a new line from the input request
    logic calc;   // emit the current pixel's first stage and step the walk
    logic scale;  // finish the byte offset and fill the output register
  } lpr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic active;    // a line is loaded and not yet finished
    logic out_busy;  // output register holds a result that is not taken
  } lpr_status_t;

endpackage

// ----- src/lpr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpr_ctrl
// Controller: accepts requests and sequences the two pixel stages.
// ----------------------------------------------------------------------------
module lpr_ctrl import lpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_kind,
  output logic        in_stall,
  input  lpr_status_t status,
  output lpr_cmd_t    cmd
);

  lpr_state_t state;
  lpr_state_t state_next;
  logic       accept;

  // Requests are taken only in the idle state, where in_stall is low.
  assign accept = in_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_kind == KindTick && status.active) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b0;
    cmd       = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load = accept && in_kind == KindStart;
        cmd.calc = accept && in_kind == KindTick && status.active;
      end
      ST_SCALE: begin
        in_stall  = 1'b1;
        cmd.scale = !status.out_busy;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

// ----- src/lpr_datapath.sv -----
// ----------------------------------------------------------------------------
// lpr_datapath
// Line state, Bresenham step, offset arithmetic and the output register.
// ----------------------------------------------------------------------------
module lpr_datapath import lpr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [DimBits-1:0] cfg_data,
  input  lpr_in_t            in_data,
  input  lpr_cmd_t           cmd,
  output lpr_status_t        status,
  output logic               out_valid,
  input  logic               out_stall,
  output lpr_out_t           out_data
);

  localparam logic [CountBits-1:0] MaxFb = CountBits'(MaxFramebuffers);

  // Configuration.
  logic [DimBits-1:0]   fb_width;
  logic [DimBits-1:0]   fb_height;
  logic [BppBits-1:0]   bytes_per_pixel;
  logic [CountBits-1:0] fb_count;

  // Line state.
  logic                   active;
  logic [CoordBits-1:0]   cur_x;
  logic [CoordBits-1:0]   cur_y;
  logic [CoordBits-1:0]   target_x;
  logic [CoordBits-1:0]   target_y;
  logic [CoordBits-1:0]   delta_x;
  logic [CoordBits-1:0]   delta_y;
  logic                   step_x_negative;
  logic                   step_y_negative;
  logic signed [ErrBits-1:0] error_term;
  logic [23:0]            line_color;
  logic [FbIndexBits-1:0] line_fb;

  // First pixel stage.
  logic [CoordBits-1:0]  pix_x;
  logic [CoordBits-1:0]  pix_y;
  logic                  pix_ok;
  logic                  pix_last;
  logic [OffsetBits-1:0] pix_sum;

  logic [CoordBits-1:0]      load_dx;
  logic [CoordBits-1:0]      load_dy;
  logic signed [ErrBits:0]   e2;
  logic signed [ErrBits:0]   dx_s;
  logic signed [ErrBits:0]   dy_s;
  logic                      x_step;
  logic                      y_step;
  logic signed [ErrBits:0]   err_next;
  logic [CountBits-1:0]      count_lim;
  logic                      ok_now;
  logic                      last_now;
  logic [OffsetBits-1:0]     sum_now;
  logic [OffsetBits+BppBits-1:0] scaled;
  logic                      out_take;

  assign load_dx = (in_data.start_x > in_data.end_x) ? in_data.start_x - in_data.end_x
                                                     : in_data.end_x - in_data.start_x;
  assign load_dy = (in_data.start_y > in_data.end_y) ? in_data.start_y - in_data.end_y
                                                     : in_data.end_y - in_data.start_y;

  assign e2       = {error_term, 1'b0};
  assign dx_s     = $signed({{(ErrBits+1-CoordBits){1'b0}}, delta_x});
  assign dy_s     = $signed({{(ErrBits+1-CoordBits){1'b0}}, delta_y});
  assign x_step   = e2 > -dy_s;
  assign y_step   = e2 < dx_s;
  assign err_next = $signed({error_term[ErrBits-1], error_term})
                    - (x_step ? dy_s : '0) + (y_step ? dx_s : '0);

  assign count_lim = (fb_count > MaxFb) ? MaxFb : fb_count;
  assign ok_now    = (CountBits'(line_fb) < count_lim)
                     && (DimBits'(cur_x) < fb_width) && (DimBits'(cur_y) < fb_height);
  assign last_now  = (cur_x == target_x) && (cur_y == target_y);
  assign sum_now   = OffsetBits'(cur_y * fb_width) + OffsetBits'(cur_x);
  assign scaled    = pix_sum * bytes_per_pixel;
  assign out_take  = out_valid && !out_stall;

  assign status.active   = active;
  assign status.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width        <= DimBits'(640);
      fb_height       <= DimBits'(480);
      bytes_per_pixel <= BppBits'(4);
      fb_count        <= CountBits'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegFbWidth:  fb_width        <= cfg_data;
        RegFbHeight: fb_height       <= cfg_data;
        RegBpp:      bytes_per_pixel <= cfg_data[BppBits-1:0];
        RegFbCount:  fb_count        <= cfg_data[CountBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cmd.load) begin
      active <= 1'b1;
    end else if (cmd.calc && last_now) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x           <= in_data.start_x;
      cur_y           <= in_data.start_y;
      target_x        <= in_data.end_x;
      target_y        <= in_data.end_y;
      delta_x         <= load_dx;
      delta_y         <= load_dy;
      step_x_negative <= !(in_data.start_x < in_data.end_x);
      step_y_negative <= !(in_data.start_y < in_data.end_y);
      error_term      <= $signed({2'b00, load_dx}) - $signed({2'b00, load_dy});
      line_color      <= {in_data.red, in_data.green, in_data.blue};
      line_fb         <= in_data.fb_index;
    end else if (cmd.calc && !last_now) begin
      error_term <= ErrBits'(err_next);
      if (x_step) begin
        cur_x <= step_x_negative ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (y_step) begin
        cur_y <= step_y_negative ? cur_y - 1'b1 : cur_y + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      pix_x    <= cur_x;
      pix_y    <= cur_y;
      pix_ok   <= ok_now;
      pix_last <= last_now;
      pix_sum  <= sum_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.scale) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      out_data.pixel_x     <= pix_x;
      out_data.pixel_y     <= pix_y;
      out_data.byte_offset <= pix_ok ? scaled[OffsetBits-1:0] : '0;
      out_data.in_bounds   <= pix_ok;
      out_data.color_red   <= line_color[23:16];
      out_data.color_green <= line_color[15:8];
      out_data.color_blue  <= line_color[7:0];
      out_data.last        <= pix_last;
    end
  end

endmodule

// ----- src/line_pixel_rasterizer.sv -----
// ----------------------------------------------------------------------------
// line_pixel_rasterizer
// Bresenham line walker producing one framebuffer pixel per tick request.
// ----------------------------------------------------------------------------
// Usage: a start request (kind = start) loads the endpoints, color and
// framebuffer index of a line and produces no result. Each tick request then
// yields one pixel, from the first endpoint to the second, with its byte
// offset (y * width + x) * bytes_per_pixel (zero when out of bounds), an
// in-bounds flag and a last marker. Ticks with no line loaded are dropped.
// Flow: a tick's pixel goes first into the first pixel stage (the width
// multiply with its add), then into the output register (the bytes-per-pixel
// multiply) once that register is free. Start requests are taken every
// cycle while the controller is idle; a tick holds off further requests.
// Configuration writes take effect at the next edge and belong in idle
// periods. The output register decouples the two sides: while a result waits
// under out_stall the next request is still accepted, and only the second
// pixel stage holds off, with the input stalled, until the register is free.
// Reset (rst, synchronous) restores the default geometry 640 x 480 with four
// bytes per pixel and one framebuffer, and drops any line in progress.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer import lpr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [DimBits-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  lpr_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lpr_out_t           out_data
);

  // Command and status between the sequencer and the arithmetic.
  lpr_cmd_t    cmd;
  lpr_status_t status;

  lpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lpr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- sim/tb_line_pixel_rasterizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_pixel_rasterizer
// Self-checking testbench for the Bresenham line pixel rasterizer.
// ----------------------------------------------------------------------------
// An initial block fills a queue of start and tick requests. It begins with a
// short directed sequence and then runs random line sequences under several
// framebuffer geometries, including the extremes of every register. A
// clocked driver offers those requests in bursts. Each accepted request goes
// through a local line walker, which queues the pixel it should produce. A
// clocked monitor compares every accepted pixel, field by field, with the
// oldest queued pixel. The receiver stalls on its own random pattern. Twice
// it holds off for a long stretch so that the block fills and stalls its
// input.
// ----------------------------------------------------------------------------
module tb_line_pixel_rasterizer;
  import lpr_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 8;      // margin after the last pixel has come out
  localparam int HoldCycles  = 300;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = RegFbWidth;
  logic [DimBits-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  lpr_in_t            in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  lpr_out_t           out_data;

  line_pixel_rasterizer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Requests waiting for the driver, and pixels the walker says must come out.
  lpr_in_t  request_queue[$];
  lpr_out_t pending_pixels[$];
  int       queued_total = 0;
  int       mismatches = 0;
  int       cycle_count = 0;

  // Local copy of the geometry registers, kept in step with every write.
  logic [DimBits-1:0]   geo_width  = 13'd640;
  logic [DimBits-1:0]   geo_height = 13'd480;
  logic [BppBits-1:0]   geo_bpp    = 3'd4;
  logic [CountBits-1:0] geo_count  = 3'd1;

  // Line walker state.
  logic                   line_on = 1'b0;
  logic [CoordBits-1:0]   walk_x = '0, walk_y = '0;
  logic [CoordBits-1:0]   goal_x = '0, goal_y = '0;
  logic [CoordBits-1:0]   span_x = '0, span_y = '0;
  logic                   back_x = 1'b0, back_y = 1'b0;
  int                     walk_err = 0;
  logic [23:0]            line_rgb = '0;
  logic [FbIndexBits-1:0] line_buf = '0;

  // Advances the walker by one accepted request and queues the pixel, if any.
  function automatic void walk_line(lpr_in_t req);
    lpr_out_t         px;
    int unsigned      buffers;
    longint unsigned  offset;
    int               twice;
    if (req.kind == KindStart) begin
      line_buf = req.fb_index;
      line_rgb = {req.red, req.green, req.blue};
      walk_x   = req.start_x;
      walk_y   = req.start_y;
      goal_x   = req.end_x;
      goal_y   = req.end_y;
      span_x   = (req.start_x > req.end_x) ? req.start_x - req.end_x : req.end_x - req.start_x;
      span_y   = (req.start_y > req.end_y) ? req.start_y - req.end_y : req.end_y - req.start_y;
      back_x   = !(req.start_x < req.end_x);
      back_y   = !(req.start_y < req.end_y);
      walk_err = int'(span_x) - int'(span_y);
      line_on  = 1'b1;
    end else if (line_on) begin
      // The framebuffer count is clamped to the supported maximum.
      buffers        = (geo_count < MaxFramebuffers) ? geo_count : MaxFramebuffers;
      px.pixel_x     = walk_x;
      px.pixel_y     = walk_y;
      px.in_bounds   = (line_buf < buffers) && (walk_x < geo_width) && (walk_y < geo_height);
      offset         = walk_y;
      offset         = (offset * geo_width + walk_x) * geo_bpp;
      px.byte_offset = px.in_bounds ? offset[OffsetBits-1:0] : '0;
      px.color_red   = line_rgb[23:16];
      px.color_green = line_rgb[15:8];
      px.color_blue  = line_rgb[7:0];
      px.last        = (walk_x == goal_x) && (walk_y == goal_y);
      pending_pixels.push_back(px);
      if (px.last) begin
        line_on = 1'b0;
      end else begin
        // Both decisions use the error term as it stood before this step.
        twice = 2 * walk_err;
        if (twice > -int'(span_y)) begin
          walk_err -= int'(span_y);
          walk_x = back_x ? walk_x - 1'b1 : walk_x + 1'b1;
        end
        if (twice < int'(span_x)) begin
          walk_err += int'(span_x);
          walk_y = back_y ? walk_y - 1'b1 : walk_y + 1'b1;
        end
      end
    end
  endfunction

  function automatic lpr_in_t random_request(logic kind);
    logic [95:0] bits;
    lpr_in_t     req;
    bits = {$urandom(), $urandom(), $urandom()};
    req = bits[$bits(lpr_in_t)-1:0];
    req.kind = kind;
    return req;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // Queues a start request followed by a number of tick requests.
  task automatic queue_line(logic [1:0] fb, int x0, int y0, int x1, int y1,
                            logic [23:0] rgb, int ticks);
    lpr_in_t req;
    req = random_request(KindStart);
    req.fb_index = fb;
    req.start_x  = CoordBits'(x0);
    req.start_y  = CoordBits'(y0);
    req.end_x    = CoordBits'(x1);
    req.end_y    = CoordBits'(y1);
    {req.red, req.green, req.blue} = rgb;
    request_queue.push_back(req);
    repeat (ticks) request_queue.push_back(random_request(KindTick));
    queued_total += ticks + 1;
  endtask

  // Mostly complete short lines near the visible area, with some long lines
  // cut short, lines overrun by extra ticks and stray ticks mixed in.
  task automatic random_lines(int count);
    int goal, roll, reach, x0, y0, x1, y1, n, ticks, lim_x, lim_y;
    logic [1:0] fb;
    goal  = queued_total + count;
    lim_x = (geo_width > 4091) ? 4095 : int'(geo_width) + 4;
    lim_y = (geo_height > 4091) ? 4095 : int'(geo_height) + 4;
    while (queued_total < goal) begin
      roll = $urandom_range(0, 19);
      if (roll == 0) begin
        request_queue.push_back(random_request(KindTick));
        queued_total++;
      end else begin
        if (roll == 1) begin
          x0 = $urandom_range(0, 4095);
          y0 = $urandom_range(0, 4095);
          x1 = $urandom_range(0, 4095);
          y1 = $urandom_range(0, 4095);
          ticks = $urandom_range(0, 24);
        end else begin
          reach = ($urandom_range(0, 3) == 0) ? 40 : 8;
          x0 = $urandom_range(0, lim_x);
          y0 = $urandom_range(0, lim_y);
          x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * reach)) - reach);
          y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * reach)) - reach);
          n = (((x1 > x0) ? x1 - x0 : x0 - x1) > ((y1 > y0) ? y1 - y0 : y0 - y1)) ?
              ((x1 > x0) ? x1 - x0 : x0 - x1) : ((y1 > y0) ? y1 - y0 : y0 - y1);
          n = n + 1;
          roll = $urandom_range(0, 9);
          if (roll == 0) ticks = $urandom_range(0, n - 1);
          else if (roll == 1) ticks = n + $urandom_range(1, 3);
          else ticks = n;
        end
        fb = ($urandom_range(0, 1) == 0) ? 2'd0 : 2'($urandom_range(0, 3));
        queue_line(fb, x0, y0, x1, y1, 24'($urandom()), ticks);
      end
    end
  endtask

  task automatic set_register(logic [1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[DimBits-1:0];
    case (idx)
      RegFbWidth:  geo_width  = val[DimBits-1:0];
      RegFbHeight: geo_height = val[DimBits-1:0];
      RegBpp:      geo_bpp    = val[BppBits-1:0];
      RegFbCount:  geo_count  = val[CountBits-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned bpp,
                              int unsigned count);
    set_register(RegFbWidth, w);
    set_register(RegFbHeight, h);
    set_register(RegBpp, bpp);
    set_register(RegFbCount, count);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every request is taken and every pixel has come out, then
  // lets the block finish any start or stray tick still in flight. The
  // check runs at the falling edge, after the driver and monitor have
  // settled for the cycle.
  task automatic drain();
    do @(negedge clk);
    while (request_queue.size() != 0 || in_valid || pending_pixels.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed lines under the reset geometry of 640 x 480, four bytes per
    // pixel and one framebuffer.
    request_queue.push_back(random_request(KindTick));   // tick with no line
    queued_total++;
    queue_line(2'd0, 0, 0, 0, 0, 24'hFF00FF, 2);            // single point, then stray tick
    queue_line(2'd3, 4095, 4095, 4093, 4092, 24'h00FF00, 4); // far corner, out of range buffer
    queue_line(2'd0, 639, 479, 641, 481, 24'hFFFFFF, 3);    // crosses the right and bottom edges
    queue_line(2'd0, 10, 10, 20, 12, 24'h000000, 3);        // dropped by the next start
    queue_line(2'd0, 5, 0, 0, 2, 24'h123456, 6);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_geometry(4096, 4096, 4, 4);
        1: set_geometry(1, 1, 1, 4);
        2: set_geometry(8191, 8191, 7, 7);   // offsets wrap, count clamps
        3: set_geometry(0, 0, 0, 0);         // nothing is in bounds
        default: set_geometry($urandom_range(1, 4096), $urandom_range(1, 4096),
                              $urandom_range(1, 4), $urandom_range(0, 4));
      endcase
      random_lines(phase == 3 ? 100 : 160);
      drain();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Driver: offers queued requests in bursts of random length with random
  // gaps, and hands every accepted request to the line walker.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) walk_line(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          in_data  <= request_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern changes at random intervals. After the
  // 150th and 600th pixel it holds off for a long stretch while the sender
  // keeps going.
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int taken = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall && (taken == 150 || taken == 600)) begin
        hold_left = HoldCycles;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 4);
          mode_left  = $urandom_range(32, 400);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 7) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          3: out_stall <= ($urandom_range(0, 7) != 0);
          default: out_stall <= !out_stall;
        endcase
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Monitor: each accepted pixel is matched against the oldest expected one.
  always @(posedge clk) begin : monitor
    lpr_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: pixel expected none, got x %0d y %0d", $time,
                 out_data.pixel_x, out_data.pixel_y);
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_x", want.pixel_x, out_data.pixel_x);
        check_field("pixel_y", want.pixel_y, out_data.pixel_y);
        check_field("byte_offset", want.byte_offset, out_data.byte_offset);
        check_field("in_bounds", want.in_bounds, out_data.in_bounds);
        check_field("color_red", want.color_red, out_data.color_red);
        check_field("color_green", want.color_green, out_data.color_green);
        check_field("color_blue", want.color_blue, out_data.color_blue);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
src/lpr_pkg.sv
src/lpr_ctrl.sv
src/lpr_datapath.sv
src/line_pixel_rasterizer.sv
sim/tb_line_pixel_rasterizer.sv
